### src/two_phase_current_vector_pwm_macros.svh
// two_phase_current_vector_pwm_macros.svh: assertion macros for the current vector pwm block
// no dependencies; included by the top level only
`ifndef TWO_PHASE_CURRENT_VECTOR_PWM_MACROS_SVH
`define TWO_PHASE_CURRENT_VECTOR_PWM_MACROS_SVH

// implication checked at every rising clock edge outside reset
`define CVPWM_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("cvpwm assertion failed");

// plain invariant outside reset
`define CVPWM_ASSERT_ALWAYS(label, clk, rst_n, cond) \
    `CVPWM_ASSERT_IMPL(label, clk, rst_n, 1'b1, cond)

`endif

### src/cvpwm_pkg.sv
// cvpwm_pkg.sv: widths, codes, types and the sine table of the current vector pwm block
// no dependencies
package cvpwm_pkg;

    localparam int ANGLE_W   = 8;
    localparam int CUR_W     = 16;
    localparam int LIM_W     = 15;
    localparam int PER_W     = 16;
    localparam int TRIG_W    = 8;
    localparam int PROD_W    = LIM_W + PER_W;
    localparam int QUOT_W    = 16;
    localparam int DUTY_W    = 16;
    localparam int SCL_W     = QUOT_W + TRIG_W;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_DAT_W = 16;
    localparam int NUM_PHASES = 2;

    // two quotient bits per divider stage
    localparam int DIV_BITS   = 2;
    localparam int DIV_STAGES = QUOT_W / DIV_BITS;

    localparam logic [LIM_W-1:0] MAX_CURRENT_RST = 15'd1000;
    localparam logic [PER_W-1:0] PWM_PERIOD_RST  = 16'd1000;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_MAX_CURRENT = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PWM_PERIOD  = 1'd1;

    // bridge direction codes
    typedef enum logic [1:0] {
        DRV_OFF = 2'd0,
        DRV_POS = 2'd1,
        DRV_NEG = 2'd2
    } t_drive;

    // trig value as sign and magnitude
    typedef struct packed {
        logic              neg;
        logic [TRIG_W-1:0] mag;
    } t_trig;

    // side data that travels with an item through the pipeline
    typedef struct packed {
        logic  neg;
        t_trig trig_a;
        t_trig trig_b;
    } t_side;

    // first quadrant of round(255*sin), 65 points
    localparam logic [TRIG_W-1:0] QUARTER_WAVE [65] = '{
        8'd0,   8'd6,   8'd13,  8'd19,  8'd25,  8'd31,  8'd37,  8'd44,  8'd50,
        8'd56,  8'd62,  8'd68,  8'd74,  8'd80,  8'd86,  8'd92,  8'd98,  8'd103,
        8'd109, 8'd115, 8'd120, 8'd126, 8'd131, 8'd136, 8'd142, 8'd147, 8'd152,
        8'd157, 8'd162, 8'd167, 8'd171, 8'd176, 8'd180, 8'd185, 8'd189, 8'd193,
        8'd197, 8'd201, 8'd205, 8'd208, 8'd212, 8'd215, 8'd219, 8'd222, 8'd225,
        8'd228, 8'd231, 8'd233, 8'd236, 8'd238, 8'd240, 8'd242, 8'd244, 8'd246,
        8'd247, 8'd249, 8'd250, 8'd251, 8'd252, 8'd253, 8'd254, 8'd254, 8'd255,
        8'd255, 8'd255
    };

    // full-turn sine from the quarter wave, folded by symmetry
    function automatic t_trig sine_lookup(input logic [ANGLE_W-1:0] angle);
        logic [ANGLE_W-2:0] half;
        logic [ANGLE_W-2:0] idx;
        t_trig              res;
        half = angle[ANGLE_W-2:0];
        if (half <= 7'd64) begin
            idx = half;
        end else begin
            idx = 7'(8'd128 - {1'b0, half});
        end
        res.neg = angle[ANGLE_W-1];
        res.mag = QUARTER_WAVE[idx];
        return res;
    endfunction

endpackage

### src/cvpwm_front.sv
// cvpwm_front.sv: current clamp, sine/cosine lookup and current-times-period product
// depends on cvpwm_pkg
module cvpwm_front (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_enable,
    input  logic                          i_valid,
    input  logic [cvpwm_pkg::ANGLE_W-1:0] i_angle,
    input  logic signed [cvpwm_pkg::CUR_W-1:0] i_current,
    input  logic [cvpwm_pkg::LIM_W-1:0]   i_max_current,
    input  logic [cvpwm_pkg::PER_W-1:0]   i_pwm_period,
    output logic                          o_valid,
    output logic [cvpwm_pkg::PROD_W-1:0]  o_product,
    output cvpwm_pkg::t_side              o_side
);

    logic [cvpwm_pkg::CUR_W-1:0]   n_abs;
    logic [cvpwm_pkg::LIM_W-1:0]   n_mag;
    logic [cvpwm_pkg::ANGLE_W-1:0] n_cos_angle;
    cvpwm_pkg::t_side              n_side;

    logic                          r_va;
    logic [cvpwm_pkg::LIM_W-1:0]   r_mag;
    cvpwm_pkg::t_side              r_side_a;
    logic                          r_vb;
    logic [cvpwm_pkg::PROD_W-1:0]  r_prod;
    cvpwm_pkg::t_side              r_side_b;

    // magnitude of the request clamped to the limit, plus both trig lookups
    always_comb begin
        n_abs = i_current[cvpwm_pkg::CUR_W-1] ? (~i_current + 16'd1) : i_current;
        if (n_abs > {1'b0, i_max_current}) begin
            n_mag = i_max_current;
        end else begin
            n_mag = n_abs[cvpwm_pkg::LIM_W-1:0];
        end
        n_cos_angle   = i_angle + 8'd64;
        n_side.neg    = i_current[cvpwm_pkg::CUR_W-1];
        n_side.trig_a = cvpwm_pkg::sine_lookup(i_angle);
        n_side.trig_b = cvpwm_pkg::sine_lookup(n_cos_angle);
    end

    // valid bits of both stages
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_va <= 1'b0;
            r_vb <= 1'b0;
        end else if (i_enable) begin
            r_va <= i_valid;
            r_vb <= r_va;
        end
    end

    // clamp stage then product stage
    always_ff @(posedge i_clk) begin
        if (i_enable) begin
            r_mag    <= n_mag;
            r_side_a <= n_side;
            r_prod   <= {16'd0, r_mag} * {15'd0, i_pwm_period};
            r_side_b <= r_side_a;
        end
    end

    assign o_valid   = r_vb;
    assign o_product = r_prod;
    assign o_side    = r_side_b;

endmodule

### src/cvpwm_div.sv
// cvpwm_div.sv: pipelined restoring divider, product over current limit, two bits a stage
// depends on cvpwm_pkg
module cvpwm_div (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_enable,
    input  logic                          i_valid,
    input  logic [cvpwm_pkg::PROD_W-1:0]  i_product,
    input  cvpwm_pkg::t_side              i_side,
    input  logic [cvpwm_pkg::LIM_W-1:0]   i_max_current,
    output logic                          o_valid,
    output logic [cvpwm_pkg::QUOT_W-1:0]  o_quot,
    output cvpwm_pkg::t_side              o_side
);

    // work word holds remainder on top and dividend bits turning into quotient below
    logic [cvpwm_pkg::PROD_W-1:0] r_work [cvpwm_pkg::DIV_STAGES];
    logic                         r_valid [cvpwm_pkg::DIV_STAGES];
    cvpwm_pkg::t_side             r_side [cvpwm_pkg::DIV_STAGES];

    // one restoring step: shift in a dividend bit, subtract if it fits
    function automatic logic [cvpwm_pkg::PROD_W-1:0] div_step(
        input logic [cvpwm_pkg::PROD_W-1:0] w,
        input logic [cvpwm_pkg::LIM_W-1:0]  d
    );
        logic [cvpwm_pkg::LIM_W:0]   t;
        logic [cvpwm_pkg::LIM_W:0]   diff;
        logic                        ge;
        logic [cvpwm_pkg::LIM_W-1:0] rem;
        t    = {w[cvpwm_pkg::PROD_W-1:cvpwm_pkg::QUOT_W], w[cvpwm_pkg::QUOT_W-1]};
        ge   = (t >= {1'b0, d});
        diff = t - {1'b0, d};
        rem  = ge ? diff[cvpwm_pkg::LIM_W-1:0] : t[cvpwm_pkg::LIM_W-1:0];
        return {rem, w[cvpwm_pkg::QUOT_W-2:0], ge};
    endfunction

    genvar gs;
    generate
        for (gs = 0; gs < cvpwm_pkg::DIV_STAGES; gs++) begin : g_stage
            logic [cvpwm_pkg::PROD_W-1:0] n_in;
            logic                         n_vin;
            cvpwm_pkg::t_side             n_side_in;
            logic [cvpwm_pkg::PROD_W-1:0] n_work;

            if (gs == 0) begin : g_first
                assign n_in      = i_product;
                assign n_vin     = i_valid;
                assign n_side_in = i_side;
            end else begin : g_next
                assign n_in      = r_work[gs-1];
                assign n_vin     = r_valid[gs-1];
                assign n_side_in = r_side[gs-1];
            end

            // two dependent steps per stage
            assign n_work = div_step(div_step(n_in, i_max_current), i_max_current);

            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_valid[gs] <= 1'b0;
                end else if (i_enable) begin
                    r_valid[gs] <= n_vin;
                end
            end

            always_ff @(posedge i_clk) begin
                if (i_enable) begin
                    r_work[gs] <= n_work;
                    r_side[gs] <= n_side_in;
                end
            end
        end
    endgenerate

    // zero limit means zero amplitude
    assign o_valid = r_valid[cvpwm_pkg::DIV_STAGES-1];
    assign o_quot  = (i_max_current == '0) ? '0 :
                     r_work[cvpwm_pkg::DIV_STAGES-1][cvpwm_pkg::QUOT_W-1:0];
    assign o_side  = r_side[cvpwm_pkg::DIV_STAGES-1];

endmodule

### src/cvpwm_phase.sv
// cvpwm_phase.sv: per-phase amplitude times trig, exact divide by 255, drive and duty
// depends on cvpwm_pkg
module cvpwm_phase (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_enable,
    input  logic                          i_valid,
    input  logic [cvpwm_pkg::QUOT_W-1:0]  i_amp,
    input  cvpwm_pkg::t_side              i_side,
    output logic                          o_valid,
    output cvpwm_pkg::t_drive             o_drive [cvpwm_pkg::NUM_PHASES],
    output logic [cvpwm_pkg::DUTY_W-1:0]  o_duty [cvpwm_pkg::NUM_PHASES]
);

    cvpwm_pkg::t_trig              n_trig [cvpwm_pkg::NUM_PHASES];

    logic                          r_v1;
    logic                          r_v2;
    logic                          r_v3;
    logic [cvpwm_pkg::SCL_W-1:0]   r_x1 [cvpwm_pkg::NUM_PHASES];
    logic                          r_neg1 [cvpwm_pkg::NUM_PHASES];
    logic [cvpwm_pkg::SCL_W-1:0]   r_x2 [cvpwm_pkg::NUM_PHASES];
    logic [cvpwm_pkg::QUOT_W:0]    r_q0 [cvpwm_pkg::NUM_PHASES];
    logic                          r_neg2 [cvpwm_pkg::NUM_PHASES];
    cvpwm_pkg::t_drive             r_drive [cvpwm_pkg::NUM_PHASES];
    logic [cvpwm_pkg::DUTY_W-1:0]  r_duty [cvpwm_pkg::NUM_PHASES];

    assign n_trig[0] = i_side.trig_a;
    assign n_trig[1] = i_side.trig_b;

    // valid bits of the three stages
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else if (i_enable) begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
    end

    genvar gl;
    generate
        for (gl = 0; gl < cvpwm_pkg::NUM_PHASES; gl++) begin : g_lane
            logic [cvpwm_pkg::SCL_W:0]    n_sum;
            logic [cvpwm_pkg::SCL_W:0]    n_r;
            logic [8:0]                   n_rem;
            logic [cvpwm_pkg::QUOT_W:0]   n_q;
            logic [cvpwm_pkg::DUTY_W-1:0] n_duty;
            cvpwm_pkg::t_drive            n_drive;

            // reciprocal estimate of x/255, at most one short
            assign n_sum = {1'b0, r_x1[gl]} + {9'd0, r_x1[gl][cvpwm_pkg::SCL_W-1:8]}
                         + {17'd0, r_x1[gl][cvpwm_pkg::SCL_W-1:16]};

            // remainder check and one correction
            always_comb begin
                n_r   = {1'b0, r_x2[gl]} - {r_q0[gl], 8'd0} + {8'd0, r_q0[gl]};
                n_rem = n_r[8:0];
                n_q   = (n_rem >= 9'd255) ? (r_q0[gl] + 17'd1) : r_q0[gl];
                n_duty = n_q[cvpwm_pkg::DUTY_W-1:0];
                if (n_duty == '0) begin
                    n_drive = cvpwm_pkg::DRV_OFF;
                end else if (r_neg2[gl]) begin
                    n_drive = cvpwm_pkg::DRV_NEG;
                end else begin
                    n_drive = cvpwm_pkg::DRV_POS;
                end
            end

            // scale, estimate, correct
            always_ff @(posedge i_clk) begin
                if (i_enable) begin
                    r_x1[gl]    <= {8'd0, i_amp} * {16'd0, n_trig[gl].mag};
                    r_neg1[gl]  <= i_side.neg ^ n_trig[gl].neg;
                    r_x2[gl]    <= r_x1[gl];
                    r_q0[gl]    <= n_sum[cvpwm_pkg::SCL_W:8];
                    r_neg2[gl]  <= r_neg1[gl];
                    r_drive[gl] <= n_drive;
                    r_duty[gl]  <= n_duty;
                end
            end

            assign o_drive[gl] = r_drive[gl];
            assign o_duty[gl]  = r_duty[gl];
        end
    endgenerate

    assign o_valid = r_v3;

endmodule

### src/two_phase_current_vector_pwm.sv
// two_phase_current_vector_pwm.sv: top level of the two-phase sine/cosine current vector pwm
// depends on cvpwm_pkg, cvpwm_front, cvpwm_div, cvpwm_phase and the macros header
//
//   channel | direction | handshake                  | beat
//   in      | input     | i_in_valid / o_in_stall    | electrical angle, target current
//   out     | output    | o_out_valid / i_out_stall  | phase a and b drive and duty
//   cfg     | input     | i_cfg_we                   | register index and data
//
// the pipeline runs through clamp and product, the divider (two quotient bits per
// stage), then trig scaling and the divide by 255; one beat per cycle unless stalled.
// synchronous active-low reset clears valid bits and loads both registers with 1000.
// a stalled result at the output freezes the whole pipeline and stalls the input.
`include "two_phase_current_vector_pwm_macros.svh"

module two_phase_current_vector_pwm (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  logic [cvpwm_pkg::ANGLE_W-1:0]     i_electrical_angle,
    input  logic signed [cvpwm_pkg::CUR_W-1:0] i_target_current,
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output logic [1:0]                        o_phase_a_drive,
    output logic [cvpwm_pkg::DUTY_W-1:0]      o_phase_a_duty,
    output logic [1:0]                        o_phase_b_drive,
    output logic [cvpwm_pkg::DUTY_W-1:0]      o_phase_b_duty,
    input  logic                              i_cfg_we,
    input  logic [cvpwm_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [cvpwm_pkg::CFG_DAT_W-1:0]   i_cfg_data
);

    logic [cvpwm_pkg::LIM_W-1:0]  r_max_current;
    logic [cvpwm_pkg::PER_W-1:0]  r_pwm_period;

    logic                         enable;
    logic                         front_valid;
    logic [cvpwm_pkg::PROD_W-1:0] front_product;
    cvpwm_pkg::t_side             front_side;
    logic                         div_valid;
    logic [cvpwm_pkg::QUOT_W-1:0] div_quot;
    cvpwm_pkg::t_side             div_side;
    cvpwm_pkg::t_drive            phase_drive [cvpwm_pkg::NUM_PHASES];
    logic [cvpwm_pkg::DUTY_W-1:0] phase_duty [cvpwm_pkg::NUM_PHASES];
    logic                         zero_limit;
    logic                         both_off;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_current <= cvpwm_pkg::MAX_CURRENT_RST;
            r_pwm_period  <= cvpwm_pkg::PWM_PERIOD_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                cvpwm_pkg::REG_MAX_CURRENT: begin
                    r_max_current <= i_cfg_data[cvpwm_pkg::LIM_W-1:0];
                end
                cvpwm_pkg::REG_PWM_PERIOD: begin
                    r_pwm_period <= i_cfg_data;
                end
                default: begin
                end
            endcase
        end
    end

    // pipeline advances unless a result is held at the output
    assign enable     = !(o_out_valid && i_out_stall);
    assign o_in_stall = !enable;

    cvpwm_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_enable      (enable),
        .i_valid       (i_in_valid),
        .i_angle       (i_electrical_angle),
        .i_current     (i_target_current),
        .i_max_current (r_max_current),
        .i_pwm_period  (r_pwm_period),
        .o_valid       (front_valid),
        .o_product     (front_product),
        .o_side        (front_side)
    );

    cvpwm_div u_div (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_enable      (enable),
        .i_valid       (front_valid),
        .i_product     (front_product),
        .i_side        (front_side),
        .i_max_current (r_max_current),
        .o_valid       (div_valid),
        .o_quot        (div_quot),
        .o_side        (div_side)
    );

    cvpwm_phase u_phase (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_enable (enable),
        .i_valid  (div_valid),
        .i_amp    (div_quot),
        .i_side   (div_side),
        .o_valid  (o_out_valid),
        .o_drive  (phase_drive),
        .o_duty   (phase_duty)
    );

    // result beat
    assign o_phase_a_drive = phase_drive[0];
    assign o_phase_a_duty  = phase_duty[0];
    assign o_phase_b_drive = phase_drive[1];
    assign o_phase_b_duty  = phase_duty[1];

    // terms for the zero limit check
    assign zero_limit = (r_max_current == '0);
    assign both_off   = (o_phase_a_drive == cvpwm_pkg::DRV_OFF)
                     && (o_phase_b_drive == cvpwm_pkg::DRV_OFF);

    // duty never exceeds the period, zero limit turns both bridges off
    `CVPWM_ASSERT_IMPL(a_duty_a_bound, i_clk, i_rst_n, o_out_valid, o_phase_a_duty <= r_pwm_period)
    `CVPWM_ASSERT_IMPL(a_duty_b_bound, i_clk, i_rst_n, o_out_valid, o_phase_b_duty <= r_pwm_period)
    `CVPWM_ASSERT_IMPL(a_zero_limit_off, i_clk, i_rst_n, o_out_valid && zero_limit, both_off)
    `CVPWM_ASSERT_ALWAYS(a_stall_cause, i_clk, i_rst_n, !o_in_stall || o_out_valid)

endmodule
